// File: hdl/tsafp_pkg.sv
// Package: word types and constants for the transport stream adaptation field parser.
`timescale 1ns / 1ps
`default_nettype none

package tsafp_pkg;

   // Packet layout
   localparam int HEADER_BYTES    = 4;
   localparam int CLOCK_REF_BYTES = 6;

   // Byte position counter width (covers every position the parser reaches)
   localparam int POS_WIDTH = 5;

   // Flag byte bit positions
   localparam int FLAG_PCR_BIT    = 4;
   localparam int FLAG_OPCR_BIT   = 3;
   localparam int FLAG_SPLICE_BIT = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_start;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  af_length;
      logic [7:0]  af_flags;
      logic [47:0] pcr_raw;
      logic [47:0] opcr_raw;
      logic [7:0]  splice_count;
   } rsp_word_type;

   // Input stage to parser core
   typedef struct packed {
      logic         valid;
      req_word_type word;
   } in_stage_type;

   // Parser core to result stage
   typedef struct packed {
      logic fire;
      logic emit;
   } step_status_type;

endpackage

`default_nettype wire

// File: hdl/ts_adaptation_field_parser_unit.sv
// Top level of the transport stream adaptation field parser.
//
// Channel | Direction | Handshake             | Word
// --------+-----------+-----------------------+-------------------------------------
// req_    | in        | req_valid / req_ready | req_word_type: data_byte, packet_start
// rsp_    | out       | rsp_valid / rsp_ready | rsp_word_type: length, flags, PCR,
//         |           |                       | OPCR, splice countdown
//
// One packet byte per cycle sustained while rsp_ is not stalled; the core
// steps one byte per clock. After its last needed byte is accepted, a result
// word passes from the input register through the parser core into the
// result register, from which it can be taken.
// Reset (synchronous, active high) empties both registers and idles the parser.
// A stalled rsp_ stalls the core, which backs up into the input register and
// then drops req_ready; no word is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module ts_adaptation_field_parser_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire tsafp_pkg::req_word_type req_word,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output tsafp_pkg::rsp_word_type      rsp_word
);

   tsafp_pkg::in_stage_type    stage;
   tsafp_pkg::step_status_type status;
   tsafp_pkg::rsp_word_type    result;
   logic                       advance;

   // Byte capture
   tsafp_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .fire      (status.fire),
      .stage     (stage)
   );

   // Position tracking and field capture; flags decide which bytes are taken
   tsafp_field_core u_core (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .advance (advance),
      .status  (status),
      .result  (result)
   );

   // Result register, loaded on the last needed byte of a packet
   tsafp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// File: hdl/tsafp_in_stage.sv
// Input register stage of the adaptation field parser.
`timescale 1ns / 1ps
`default_nettype none

module tsafp_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire tsafp_pkg::req_word_type req_word,
   input  wire logic                  fire,
   output tsafp_pkg::in_stage_type    stage
);

   logic                    valid_ff, valid_in;
   tsafp_pkg::req_word_type word_ff;

   // Slot is free when empty or being drained this cycle
   assign req_ready = !valid_ff || fire;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.word  = word_ff;

endmodule

`default_nettype wire

// File: hdl/tsafp_field_core.sv
// Parser core: byte position tracking and field capture, one byte per cycle while advance is high.
`timescale 1ns / 1ps
`default_nettype none

module tsafp_field_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tsafp_pkg::in_stage_type stage,
   input  wire logic                    advance,
   output tsafp_pkg::step_status_type   status,
   output tsafp_pkg::rsp_word_type      result
);

   localparam logic [5:0] POS_LEN   = 6'(tsafp_pkg::HEADER_BYTES);
   localparam logic [5:0] POS_FLAGS = 6'(tsafp_pkg::HEADER_BYTES + 1);
   localparam logic [5:0] PCR_START = 6'(tsafp_pkg::HEADER_BYTES + 2);
   localparam logic [5:0] REF_LEN   = 6'(tsafp_pkg::CLOCK_REF_BYTES);

   logic [tsafp_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic        active_ff, active_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  flags_ff, flags_in;
   logic [47:0] pcr_ff, pcr_in;
   logic [47:0] opcr_ff, opcr_in;
   logic [7:0]  splice_ff, splice_in;

   logic        fire, start, proceed, emit;
   logic [7:0]  b;
   logic [5:0]  pos;
   logic        has_pcr, has_opcr, has_splice;
   logic [5:0]  opcr_start, splice_pos, end_pos;

   assign fire  = stage.valid && advance;
   assign start = stage.word.packet_start;
   assign b     = stage.word.data_byte;

   always_comb begin
      proceed    = fire && (start || active_ff);
      pos_in     = pos_ff;
      active_in  = active_ff;
      length_in  = length_ff;
      flags_in   = flags_ff;
      pcr_in     = pcr_ff;
      opcr_in    = opcr_ff;
      splice_in  = splice_ff;
      emit       = 1'b0;
      has_pcr    = 1'b0;
      has_opcr   = 1'b0;
      has_splice = 1'b0;
      opcr_start = PCR_START;
      splice_pos = PCR_START;
      end_pos    = PCR_START;
      pos        = '0;

      if (proceed) begin
         if (start) begin
            // new packet: fields cleared, this byte is byte zero
            pos_in    = '0;
            length_in = '0;
            flags_in  = '0;
            pcr_in    = '0;
            opcr_in   = '0;
            splice_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
         active_in = 1'b1;
         pos       = 6'(pos_in);

         if (pos == POS_LEN) begin
            length_in = b;
            emit      = (b == 8'd0);
         end else if (pos > POS_LEN) begin
            if (pos == POS_FLAGS) begin
               flags_in = b;
            end
            has_pcr    = flags_in[tsafp_pkg::FLAG_PCR_BIT];
            has_opcr   = flags_in[tsafp_pkg::FLAG_OPCR_BIT];
            has_splice = flags_in[tsafp_pkg::FLAG_SPLICE_BIT];
            opcr_start = PCR_START + (has_pcr ? REF_LEN : 6'd0);
            splice_pos = opcr_start + (has_opcr ? REF_LEN : 6'd0);
            end_pos    = splice_pos + {5'd0, has_splice};

            if (pos >= PCR_START) begin
               if (has_pcr && pos < PCR_START + REF_LEN) begin
                  pcr_in = {pcr_in[39:0], b};
               end
               if (has_opcr && pos >= opcr_start && pos < opcr_start + REF_LEN) begin
                  opcr_in = {opcr_in[39:0], b};
               end
               if (has_splice && pos == splice_pos) begin
                  splice_in = b;
               end
            end
            emit = (pos + 6'd1 >= end_pos);
         end

         if (emit) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         active_ff <= 1'b0;
         length_ff <= '0;
         flags_ff  <= '0;
         pcr_ff    <= '0;
         opcr_ff   <= '0;
         splice_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         length_ff <= length_in;
         flags_ff  <= flags_in;
         pcr_ff    <= pcr_in;
         opcr_ff   <= opcr_in;
         splice_ff <= splice_in;
      end
   end

   assign status.fire = fire;
   assign status.emit = emit;

   assign result.af_length    = length_in;
   assign result.af_flags     = flags_in;
   assign result.pcr_raw      = pcr_in;
   assign result.opcr_raw     = opcr_in;
   assign result.splice_count = splice_in;

endmodule

`default_nettype wire

// File: hdl/tsafp_out_stage.sv
// Result register stage of the adaptation field parser.
`timescale 1ns / 1ps
`default_nettype none

module tsafp_out_stage (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire tsafp_pkg::step_status_type status,
   input  wire tsafp_pkg::rsp_word_type    result,
   output logic                            advance,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output tsafp_pkg::rsp_word_type         rsp_word
);

   logic                    valid_ff, valid_in;
   logic                    load;
   tsafp_pkg::rsp_word_type word_ff;

   // Core may step when the result slot is empty or draining
   assign advance = !valid_ff || rsp_ready;
   assign load    = status.fire && status.emit;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

// File: hdl/tsafp_checker.sv
// Port-level checker for the adaptation field parser, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module tsafp_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire tsafp_pkg::rsp_word_type rsp_word
);

   // Stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // Empty adaptation field carries nothing else
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.af_length == 8'd0 |->
         rsp_word.af_flags == 8'd0 && rsp_word.pcr_raw == 48'd0 &&
         rsp_word.opcr_raw == 48'd0 && rsp_word.splice_count == 8'd0)
      else $error("fields set with zero field length");

   // Optional fields absent unless flagged
   a_pcr_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.af_flags[tsafp_pkg::FLAG_PCR_BIT] |->
         rsp_word.pcr_raw == 48'd0 && rsp_word.opcr_raw == 48'd0 ||
         rsp_word.af_flags[tsafp_pkg::FLAG_OPCR_BIT] && rsp_word.pcr_raw == 48'd0)
      else $error("PCR set without PCR flag");

   a_splice_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.af_flags[tsafp_pkg::FLAG_SPLICE_BIT] |->
         rsp_word.splice_count == 8'd0)
      else $error("splice countdown set without splicing point flag");

   // Out of reset with no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ts_adaptation_field_parser_unit tsafp_checker u_tsafp_checker (.*);

`default_nettype wire
